@@ src/i2cdp_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cdp_pkg: shared types and constants for the digipot wiper I2C master
// Beat payloads, configuration struct, bus phase codes and command bytes.
// ----------------------------------------------------------------------------
package i2cdp_pkg;

    // Input beat: one clock tick of the bus engine.
    typedef struct packed {
        logic       start_request;
        logic       op;
        logic [6:0] device_address;
        logic [2:0] channel;
        logic [8:0] wiper_value;
        logic       sda_sample;
    } t_in_item;

    // Result beat: pin levels and flags after the tick.
    typedef struct packed {
        logic        scl_release;
        logic        sda_release;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] read_word;
    } t_out_item;

    typedef struct packed {
        logic [15:0] half_bit_ticks;
        logic [15:0] ack_wait_limit;
    } t_bus_cfg;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_START_PREP  = 4'd1,
        PH_START_SETUP = 4'd2,
        PH_START_HOLD  = 4'd3,
        PH_TX_LOW      = 4'd4,
        PH_TX_HIGH     = 4'd5,
        PH_ACK_LOW     = 4'd6,
        PH_ACK_HIGH    = 4'd7,
        PH_RX_LOW      = 4'd8,
        PH_RX_HIGH     = 4'd9,
        PH_MACK_LOW    = 4'd10,
        PH_MACK_HIGH   = 4'd11,
        PH_STOP_LOW    = 4'd12,
        PH_STOP_HIGH   = 4'd13
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_ACK      = 2'd1,
        ST_BAD_CHANNEL = 2'd2
    } t_status;

    // Configuration register indexes
    localparam logic CFG_HALF_BIT_TICKS = 1'b0;
    localparam logic CFG_ACK_WAIT_LIMIT = 1'b1;

    localparam logic [15:0] HALF_BIT_TICKS_RST = 16'd250;
    localparam logic [15:0] ACK_WAIT_LIMIT_RST = 16'd800;

    // Command bytes
    localparam logic [7:0] CMD_WRITE_W0 = 8'h00;
    localparam logic [7:0] CMD_WRITE_W1 = 8'h10;
    localparam logic [7:0] CMD_READ_W0  = 8'h0C;
    localparam logic [7:0] CMD_READ_W1  = 8'h1C;

    // Sequence steps of a transaction
    localparam logic [2:0] SEQ_ADDR   = 3'd1;
    localparam logic [2:0] SEQ_CMD    = 3'd2;
    localparam logic [2:0] SEQ_DATA   = 3'd3;
    localparam logic [2:0] SEQ_RSTART = 3'd3;
    localparam logic [2:0] SEQ_RADDR  = 3'd4;
    localparam logic [2:0] SEQ_RX_HI  = 3'd5;
    localparam logic [2:0] SEQ_RX_LO  = 3'd6;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

@@ src/i2cdp_core.sv @@
// ----------------------------------------------------------------------------
// i2cdp_core: bus sequencer state and single-tick update
// Holds the transaction state and computes one tick's pin levels and flags.
// ----------------------------------------------------------------------------
module i2cdp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  i2cdp_pkg::t_in_item  i_item,
    input  i2cdp_pkg::t_bus_cfg  i_cfg,
    output i2cdp_pkg::t_out_item o_result
);
    import i2cdp_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [15:0] r_tick,     n_tick;
    logic [15:0] r_ack_wait, n_ack_wait;
    logic [3:0]  r_bit_idx,  n_bit_idx;
    logic [7:0]  r_shift,    n_shift;
    logic [15:0] r_accum,    n_accum;
    logic        r_op,       n_op;
    logic [6:0]  r_addr,     n_addr;
    logic        r_wiper,    n_wiper;
    logic [8:0]  r_value,    n_value;
    logic [2:0]  r_seq,      n_seq;
    logic        r_nack,     n_nack;

    logic [15:0] half_eff;
    logic [15:0] tick_inc;
    logic [2:0]  seq_inc;
    logic        d8;
    logic        done;
    t_status     status;
    logic [15:0] word;
    logic        scl_o;
    logic        sda_o;

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_ack_wait = r_ack_wait;
        n_bit_idx  = r_bit_idx;
        n_shift    = r_shift;
        n_accum    = r_accum;
        n_op       = r_op;
        n_addr     = r_addr;
        n_wiper    = r_wiper;
        n_value    = r_value;
        n_seq      = r_seq;
        n_nack     = r_nack;
        done       = 1'b0;
        status     = ST_OK;
        word       = '0;

        half_eff = (i_cfg.half_bit_ticks == '0) ? 16'd1 : i_cfg.half_bit_ticks;
        tick_inc = r_tick + 16'd1;
        seq_inc  = r_seq + 3'd1;
        d8       = r_value[8];

        if (r_phase == PH_IDLE) begin
            if (i_item.start_request) begin
                if (i_item.channel > 3'd3) begin
                    done   = 1'b1;
                    status = ST_BAD_CHANNEL;
                end else begin
                    n_op       = i_item.op;
                    n_addr     = i_item.device_address;
                    n_wiper    = (i_item.channel == 3'd1) || (i_item.channel == 3'd2);
                    n_value    = i_item.wiper_value;
                    n_seq      = '0;
                    n_nack     = 1'b0;
                    n_accum    = '0;
                    n_bit_idx  = '0;
                    n_shift    = '0;
                    n_ack_wait = '0;
                    n_phase    = PH_START_SETUP;
                    n_tick     = '0;
                end
            end
        end else if (r_phase == PH_ACK_HIGH) begin
            if (!i_item.sda_sample) begin
                n_phase = PH_STOP_LOW;  // overridden by the sequence step below
            end else begin
                if (r_ack_wait != 16'hFFFF) begin
                    n_ack_wait = r_ack_wait + 16'd1;
                end
                if (n_ack_wait >= i_cfg.ack_wait_limit) begin
                    n_nack  = 1'b1;
                    n_phase = PH_STOP_LOW;
                    n_tick  = '0;
                end
            end
        end else begin
            n_tick = tick_inc;
            if (tick_inc >= half_eff) begin
                n_tick = '0;
                case (r_phase)
                    PH_START_PREP:  n_phase = PH_START_SETUP;
                    PH_START_SETUP: n_phase = PH_START_HOLD;
                    PH_START_HOLD:  n_phase = PH_STOP_LOW;
                    PH_TX_LOW:      n_phase = PH_TX_HIGH;
                    PH_TX_HIGH: begin
                        n_shift   = {r_shift[6:0], 1'b0};
                        n_bit_idx = r_bit_idx + 4'd1;
                        n_phase   = (n_bit_idx >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
                    end
                    PH_ACK_LOW: begin
                        n_ack_wait = '0;
                        n_phase    = PH_ACK_HIGH;
                    end
                    PH_RX_LOW:      n_phase = PH_RX_HIGH;
                    PH_RX_HIGH: begin
                        n_accum   = {r_accum[14:0], i_item.sda_sample};
                        n_bit_idx = r_bit_idx + 4'd1;
                        n_phase   = (n_bit_idx >= BITS_PER_BYTE) ? PH_MACK_LOW : PH_RX_LOW;
                    end
                    PH_MACK_LOW:    n_phase = PH_MACK_HIGH;
                    PH_MACK_HIGH:   n_phase = PH_STOP_LOW;
                    PH_STOP_LOW:    n_phase = PH_STOP_HIGH;
                    PH_STOP_HIGH: begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                        status  = r_nack ? ST_NO_ACK : ST_OK;
                        if (!r_nack && r_op) begin
                            word = r_accum;
                        end
                    end
                    default:        n_phase = PH_IDLE;
                endcase
            end
        end

        // Advance the transaction sequence: ACK seen, START held, or master ACK sent.
        if (((r_phase == PH_ACK_HIGH) && !i_item.sda_sample) ||
            (((r_phase == PH_START_HOLD) || (r_phase == PH_MACK_HIGH)) &&
             (tick_inc >= half_eff))) begin
            n_seq  = seq_inc;
            n_tick = '0;
            if (!r_op) begin
                case (seq_inc)
                    SEQ_ADDR: begin
                        n_shift   = {r_addr, 1'b0};
                        n_bit_idx = '0;
                        n_phase   = PH_TX_LOW;
                    end
                    SEQ_CMD: begin
                        n_shift   = (r_wiper ? CMD_WRITE_W1 : CMD_WRITE_W0) | {7'd0, d8};
                        n_bit_idx = '0;
                        n_phase   = PH_TX_LOW;
                    end
                    SEQ_DATA: begin
                        n_shift   = d8 ? 8'd0 : r_value[7:0];
                        n_bit_idx = '0;
                        n_phase   = PH_TX_LOW;
                    end
                    default: n_phase = PH_STOP_LOW;
                endcase
            end else begin
                case (seq_inc)
                    SEQ_ADDR: begin
                        n_shift   = {r_addr, 1'b0};
                        n_bit_idx = '0;
                        n_phase   = PH_TX_LOW;
                    end
                    SEQ_CMD: begin
                        n_shift   = r_wiper ? CMD_READ_W1 : CMD_READ_W0;
                        n_bit_idx = '0;
                        n_phase   = PH_TX_LOW;
                    end
                    SEQ_RSTART: n_phase = PH_START_PREP;
                    SEQ_RADDR: begin
                        n_shift   = {r_addr, 1'b1};
                        n_bit_idx = '0;
                        n_phase   = PH_TX_LOW;
                    end
                    SEQ_RX_HI, SEQ_RX_LO: begin
                        n_bit_idx = '0;
                        n_phase   = PH_RX_LOW;
                    end
                    default: n_phase = PH_STOP_LOW;
                endcase
            end
        end

        // Pin levels follow the updated phase.
        case (n_phase)
            PH_START_PREP: begin
                scl_o = 1'b0;
                sda_o = 1'b1;
            end
            PH_START_HOLD: begin
                scl_o = 1'b1;
                sda_o = 1'b0;
            end
            PH_TX_LOW: begin
                scl_o = 1'b0;
                sda_o = n_shift[7];
            end
            PH_TX_HIGH: begin
                scl_o = 1'b1;
                sda_o = n_shift[7];
            end
            PH_ACK_LOW, PH_RX_LOW: begin
                scl_o = 1'b0;
                sda_o = 1'b1;
            end
            PH_MACK_LOW: begin
                scl_o = 1'b0;
                sda_o = (n_seq == SEQ_RX_LO);
            end
            PH_MACK_HIGH: begin
                scl_o = 1'b1;
                sda_o = (n_seq == SEQ_RX_LO);
            end
            PH_STOP_LOW: begin
                scl_o = 1'b0;
                sda_o = 1'b0;
            end
            PH_STOP_HIGH: begin
                scl_o = 1'b1;
                sda_o = 1'b0;
            end
            default: begin
                scl_o = 1'b1;
                sda_o = 1'b1;
            end
        endcase

        o_result.scl_release = scl_o;
        o_result.sda_release = sda_o;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = done;
        o_result.status      = status;
        o_result.read_word   = word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_ack_wait <= '0;
            r_bit_idx  <= '0;
            r_shift    <= '0;
            r_accum    <= '0;
            r_op       <= 1'b0;
            r_addr     <= '0;
            r_wiper    <= 1'b0;
            r_value    <= '0;
            r_seq      <= '0;
            r_nack     <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_ack_wait <= n_ack_wait;
            r_bit_idx  <= n_bit_idx;
            r_shift    <= n_shift;
            r_accum    <= n_accum;
            r_op       <= n_op;
            r_addr     <= n_addr;
            r_wiper    <= n_wiper;
            r_value    <= n_value;
            r_seq      <= n_seq;
            r_nack     <= n_nack;
        end
    end

endmodule

@@ src/i2c_digipot_wiper_master_top.sv @@
// Path: an accepted input beat waits in the input register, and its result
//   beat is offered from the result register.
// Throughput: one beat per cycle while the sink does not stall; the whole
//   tick update sits between the two registers, so no beat waits on the one before it.
// Reset: synchronous, active low; returns the sequencer to idle, the timing
//   registers to 250 and 800 ticks, and empties both beat registers.
// ----------------------------------------------------------------------------
// i2c_digipot_wiper_master_top: I2C master for a dual-wiper digital pot
// Each input beat is one tick of the bus engine; each tick yields one result
// beat with the SCL/SDA pin levels and the transaction flags.
// ----------------------------------------------------------------------------
module i2c_digipot_wiper_master_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input beats
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  i2cdp_pkg::t_in_item  i_in_data,
    // result beats
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output i2cdp_pkg::t_out_item o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import i2cdp_pkg::*;

    // Configuration registers
    t_bus_cfg  r_cfg;

    // Input register: one beat waiting for its tick update.
    logic      r_in_valid;
    t_in_item  r_in_data;

    // Result register: holds the finished beat until the sink takes it.
    logic      r_out_valid;
    t_out_item r_out_data;

    t_out_item core_result;
    logic      out_blocked;
    logic      step;
    logic      in_take;

    // The result register is blocked only while it holds a beat the sink stalls.
    assign out_blocked = r_out_valid && i_out_stall;
    // Run one tick whenever a beat is waiting and the result register can load.
    assign step        = r_in_valid && !out_blocked;
    // Stall upstream only when the input register cannot drain this cycle.
    assign o_in_stall  = r_in_valid && out_blocked;
    assign in_take     = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_ticks <= HALF_BIT_TICKS_RST;
            r_cfg.ack_wait_limit <= ACK_WAIT_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HALF_BIT_TICKS: r_cfg.half_bit_ticks <= i_cfg_data;
                CFG_ACK_WAIT_LIMIT: r_cfg.ack_wait_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the input beat until its tick runs; load a new one in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    // Capture the result of each tick; keep it while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= step || out_blocked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= core_result;
        end
    end

    i2cdp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_data),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

endmodule
